/* rtl/core/rwbi_pkg.sv */
// Shared types, register map and rail window constants for the rail window
// blink indicator. No dependencies; every other file in rtl/core uses it.
package rwbi_pkg;

    localparam int VoltW    = 16;
    localparam int RailN    = 7;
    localparam int CntW     = 16;
    localparam int ApbAddrW = 4;
    localparam int ApbDataW = 32;
    localparam int InDataW  = RailN * VoltW;
    localparam int OutDataW = 8;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SLOW_LIMIT = 2'd0;
    localparam logic [1:0] REG_FAST_LIMIT = 2'd1;
    localparam logic [1:0] REG_BLINK_ON   = 2'd2;

    localparam logic [CntW-1:0] SLOW_LIMIT_RST = 16'd1000;
    localparam logic [CntW-1:0] FAST_LIMIT_RST = 16'd100;
    localparam logic [CntW-1:0] BLINK_ON_RST   = 16'd50;

    // Rail windows in mV, strict compares
    localparam logic [VoltW-1:0] BAT_LO  = 16'd22000;
    localparam logic [VoltW-1:0] BAT_HI  = 16'd29000;
    localparam logic [VoltW-1:0] B24_LO  = 16'd23500;
    localparam logic [VoltW-1:0] B24_HI  = 16'd24500;
    localparam logic [VoltW-1:0] CHG_LO  = 16'd23000;
    localparam logic [VoltW-1:0] CHG_HI  = 16'd30000;
    localparam logic [VoltW-1:0] PRN_LO  = 16'd22000;
    localparam logic [VoltW-1:0] PRN_HI  = 16'd25000;
    localparam logic [VoltW-1:0] B12_LO  = 16'd11500;
    localparam logic [VoltW-1:0] B12_HI  = 16'd12500;
    localparam logic [VoltW-1:0] B36_LO  = 16'd34000;
    localparam logic [VoltW-1:0] B36_HI  = 16'd38000;
    localparam logic [VoltW-1:0] PC19_LO = 16'd18500;
    localparam logic [VoltW-1:0] PC19_HI = 16'd19500;

    typedef struct packed {
        logic [CntW-1:0] slow_limit;
        logic [CntW-1:0] fast_limit;
        logic [CntW-1:0] blink_on;
    } cfg_t;

    typedef struct packed {
        logic slow_lit;
        logic fast_lit;
    } lit_t;

    typedef struct packed {
        logic [VoltW-1:0] battery_mv;
        logic [VoltW-1:0] bus24_mv;
        logic [VoltW-1:0] charger_mv;
        logic [VoltW-1:0] printer_mv;
        logic [VoltW-1:0] bus12_mv;
        logic [VoltW-1:0] bus36_mv;
        logic [VoltW-1:0] pc_mv;
        logic             on_mains;
    } rails_t;

    // Below the window blink slow, above blink fast, inside steady on
    function automatic logic window_led(input logic [VoltW-1:0] v,
                                        input logic [VoltW-1:0] lo,
                                        input logic [VoltW-1:0] hi,
                                        input lit_t             lit);
        logic led;
        if (v < lo)
        begin
            led = lit.slow_lit;
        end
        else if (v > hi)
        begin
            led = lit.fast_lit;
        end
        else
        begin
            led = 1'b1;
        end
        return led;
    endfunction

endpackage

/* rtl/core/rwbi_cfg.sv */
// APB register file: slow/fast wrap limits and blink on-time.
// Depends on rwbi_pkg.
module rwbi_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rwbi_pkg::ApbAddrW-1:0]  paddr,
    input  logic [rwbi_pkg::ApbDataW-1:0]  pwdata,
    output logic [rwbi_pkg::ApbDataW-1:0]  prdata,
    output logic                           pready,
    output rwbi_pkg::cfg_t                 cfg
);

    rwbi_pkg::cfg_t cfg_reg;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_limit <= rwbi_pkg::SLOW_LIMIT_RST;
            cfg_reg.fast_limit <= rwbi_pkg::FAST_LIMIT_RST;
            cfg_reg.blink_on   <= rwbi_pkg::BLINK_ON_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                rwbi_pkg::REG_SLOW_LIMIT: cfg_reg.slow_limit <= pwdata[rwbi_pkg::CntW-1:0];
                rwbi_pkg::REG_FAST_LIMIT: cfg_reg.fast_limit <= pwdata[rwbi_pkg::CntW-1:0];
                rwbi_pkg::REG_BLINK_ON:   cfg_reg.blink_on   <= pwdata[rwbi_pkg::CntW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            rwbi_pkg::REG_SLOW_LIMIT:
                prdata = {{(rwbi_pkg::ApbDataW-rwbi_pkg::CntW){1'b0}}, cfg_reg.slow_limit};
            rwbi_pkg::REG_FAST_LIMIT:
                prdata = {{(rwbi_pkg::ApbDataW-rwbi_pkg::CntW){1'b0}}, cfg_reg.fast_limit};
            rwbi_pkg::REG_BLINK_ON:
                prdata = {{(rwbi_pkg::ApbDataW-rwbi_pkg::CntW){1'b0}}, cfg_reg.blink_on};
            default:
                prdata = '0;
        endcase
    end

endmodule

/* rtl/core/rwbi_count.sv */
// Slow and fast free-running blink counters, advanced once per request,
// and the lit flags derived from them. Depends on rwbi_pkg.
module rwbi_count (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  rwbi_pkg::cfg_t cfg,
    output rwbi_pkg::lit_t lit
);

    logic [rwbi_pkg::CntW-1:0] slow_count_reg;
    logic [rwbi_pkg::CntW-1:0] slow_count_next;
    logic [rwbi_pkg::CntW-1:0] fast_count_reg;
    logic [rwbi_pkg::CntW-1:0] fast_count_next;

    // Clear once past the limit, else add one (wraps at full width)
    assign slow_count_next = (slow_count_reg > cfg.slow_limit) ? '0 : slow_count_reg + 1'b1;
    assign fast_count_next = (fast_count_reg > cfg.fast_limit) ? '0 : fast_count_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_count_reg <= '0;
            fast_count_reg <= '0;
        end
        else if (advance)
        begin
            slow_count_reg <= slow_count_next;
            fast_count_reg <= fast_count_next;
        end
    end

    // Counters hold the values for the request sitting in the input register
    assign lit.slow_lit = slow_count_reg < cfg.blink_on;
    assign lit.fast_lit = fast_count_reg < cfg.blink_on;

endmodule

/* rtl/core/rwbi_decide.sv */
// Window compares for the seven rails, giving the seven LED levels.
// Depends on rwbi_pkg.
module rwbi_decide (
    input  rwbi_pkg::rails_t         rails,
    input  rwbi_pkg::lit_t           lit,
    output logic [rwbi_pkg::RailN-1:0] leds
);

    logic pc_steady;

    assign pc_steady = ((rails.pc_mv > rwbi_pkg::B12_LO) && (rails.pc_mv < rwbi_pkg::B12_HI))
                    || ((rails.pc_mv > rwbi_pkg::PC19_LO) && (rails.pc_mv < rwbi_pkg::PC19_HI));

    always_comb
    begin
        leds[0] = rwbi_pkg::window_led(rails.battery_mv, rwbi_pkg::BAT_LO,
                                       rwbi_pkg::BAT_HI, lit);
        leds[1] = rwbi_pkg::window_led(rails.bus24_mv, rwbi_pkg::B24_LO,
                                       rwbi_pkg::B24_HI, lit);

        // Low charger blinks only on mains; on battery it stays on
        if ((rails.charger_mv < rwbi_pkg::CHG_LO) && rails.on_mains)
        begin
            leds[2] = lit.slow_lit;
        end
        else if (rails.charger_mv > rwbi_pkg::CHG_HI)
        begin
            leds[2] = lit.fast_lit;
        end
        else
        begin
            leds[2] = 1'b1;
        end

        leds[3] = rwbi_pkg::window_led(rails.printer_mv, rwbi_pkg::PRN_LO,
                                       rwbi_pkg::PRN_HI, lit);
        leds[4] = rwbi_pkg::window_led(rails.bus12_mv, rwbi_pkg::B12_LO,
                                       rwbi_pkg::B12_HI, lit);
        leds[5] = rwbi_pkg::window_led(rails.bus36_mv, rwbi_pkg::B36_LO,
                                       rwbi_pkg::B36_HI, lit);

        // PC supply: steady in the 12 V or 19 V window, fast above 19 V top, else slow
        if (pc_steady)
        begin
            leds[6] = 1'b1;
        end
        else if (rails.pc_mv > rwbi_pkg::PC19_HI)
        begin
            leds[6] = lit.fast_lit;
        end
        else
        begin
            leds[6] = lit.slow_lit;
        end
    end

endmodule

/* rtl/core/rail_window_blink_indicator_top.sv */
// Rail window blink indicator: input register, counters, window compares,
// result register. Depends on rwbi_pkg, rwbi_cfg, rwbi_count, rwbi_decide.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tdata: 7 rail voltages (16b each), tuser: on_mains
//  m_axis   | out       | tdata: 7 LED levels (1b each), bit 7 zero
//  apb      | in/out    | slow_wrap_limit, fast_wrap_limit, blink_on_ticks
//
// One request per cycle sustained while m_axis is not stalled; the result passes
// through the input register, then the result register.
// Counters advance at acceptance, so a stall on m_axis holds them with the
// request waiting in the input register. Reset clears valids and counters
// and loads register defaults; there is no clearing pass.
module rail_window_blink_indicator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // battery, bus24, charger, printer, bus12, bus36, pc (mV), low bits first
    input  logic [rwbi_pkg::InDataW-1:0]        s_axis_tdata,
    // on_mains
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // led_battery, led_bus24, led_charger, led_printer, led_bus12,
    // led_bus36, led_pc, zero pad
    output logic [rwbi_pkg::OutDataW-1:0]       m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rwbi_pkg::ApbAddrW-1:0]       paddr,
    input  logic [rwbi_pkg::ApbDataW-1:0]       pwdata,
    output logic [rwbi_pkg::ApbDataW-1:0]       prdata,
    output logic                                pready
);

    localparam int VW = rwbi_pkg::VoltW;

    rwbi_pkg::cfg_t   cfg;
    rwbi_pkg::lit_t   lit;
    rwbi_pkg::rails_t rails_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic [rwbi_pkg::RailN-1:0] leds;
    logic [rwbi_pkg::RailN-1:0] leds_reg;
    logic             in_accept;
    logic             move;

    assign move          = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | move;
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    rwbi_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rwbi_count u_count (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_accept),
        .cfg     (cfg),
        .lit     (lit)
    );

    rwbi_decide u_decide (
        .rails (rails_reg),
        .lit   (lit),
        .leds  (leds)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rails_reg.battery_mv <= s_axis_tdata[0*VW +: VW];
            rails_reg.bus24_mv   <= s_axis_tdata[1*VW +: VW];
            rails_reg.charger_mv <= s_axis_tdata[2*VW +: VW];
            rails_reg.printer_mv <= s_axis_tdata[3*VW +: VW];
            rails_reg.bus12_mv   <= s_axis_tdata[4*VW +: VW];
            rails_reg.bus36_mv   <= s_axis_tdata[5*VW +: VW];
            rails_reg.pc_mv      <= s_axis_tdata[6*VW +: VW];
            rails_reg.on_mains   <= s_axis_tuser;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (~out_valid_reg | m_axis_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            leds_reg <= leds;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(rwbi_pkg::OutDataW-rwbi_pkg::RailN){1'b0}}, leds_reg};

endmodule
